// File: src/cirs_pkg.sv
`timescale 1ns / 1ps

package cirs_pkg;

  // Fixed field widths
  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int TOTAL_W  = 9;
  localparam int COUNT_W  = 33;

  // Command codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_RD_LAST,
    S_CHECK,
    S_STEP,
    S_SEARCH,
    S_DECIDE,
    S_SHIFT,
    S_SHIFT_END,
    S_PUT,
    S_DONE
  } state_t;

  // Write enables for the two range tables
  typedef struct packed {
    logic wr_start;
    logic wr_end;
  } mem_wen_t;

  // v is exactly one above e, checked with a sign-extended extra bit
  function automatic logic is_next(logic signed [VALUE_W-1:0] v,
                                   logic signed [VALUE_W-1:0] e);
    logic [VALUE_W:0] ve;
    logic [VALUE_W:0] ee;
    ve = {v[VALUE_W-1], v};
    ee = {e[VALUE_W-1], e};
    return ve == (ee + (VALUE_W+1)'(1));
  endfunction

  // v is exactly one below s
  function automatic logic is_prev(logic signed [VALUE_W-1:0] v,
                                   logic signed [VALUE_W-1:0] s);
    logic [VALUE_W:0] vs;
    logic [VALUE_W:0] ss;
    vs = {v[VALUE_W-1], v};
    ss = {s[VALUE_W-1], s};
    return vs == (ss - (VALUE_W+1)'(1));
  endfunction

endpackage

// File: src/cirs_cmd_if.sv
`timescale 1ns / 1ps

interface cirs_cmd_if;
  import cirs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

// File: src/cirs_rsp_if.sv
`timescale 1ns / 1ps

interface cirs_rsp_if;
  import cirs_pkg::*;

  logic                valid;
  logic                ready;
  logic                present;
  logic                status;
  logic [TOTAL_W-1:0]  range_total;
  logic [COUNT_W-1:0]  element_total;

  modport source (output valid, present, status, range_total, element_total, input ready);
  modport sink   (input valid, present, status, range_total, element_total, output ready);
endinterface

// File: src/cirs_range_mem.sv
`timescale 1ns / 1ps

// Range table: start and end arrays sharing one read address and one
// write address, registered read data.
module cirs_range_mem #(
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic [$clog2(DEPTH)-1:0]             rd_addr,
  output logic signed [cirs_pkg::VALUE_W-1:0]  rd_start,
  output logic signed [cirs_pkg::VALUE_W-1:0]  rd_end,
  input  cirs_pkg::mem_wen_t                   wen,
  input  logic [$clog2(DEPTH)-1:0]             wr_addr,
  input  logic signed [cirs_pkg::VALUE_W-1:0]  wr_sdata,
  input  logic signed [cirs_pkg::VALUE_W-1:0]  wr_edata
);
  import cirs_pkg::*;

  logic [VALUE_W-1:0] start_mem [DEPTH];
  logic [VALUE_W-1:0] end_mem   [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wen.wr_start) begin
      start_mem[wr_addr] <= wr_sdata;
    end
    if (wen.wr_end) begin
      end_mem[wr_addr] <= wr_edata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_start <= start_mem[rd_addr];
    rd_end   <= end_mem[rd_addr];
  end

endmodule

// File: src/coalescing_integer_range_set_unit.sv
`timescale 1ns / 1ps

// Sorted set of signed 32-bit integers kept as up to MAX_RANGES disjoint,
// non-adjacent ranges in a single-port-read range table. One command is
// handled at a time; a result can wait in the output register while the
// next command is taken. Add and find read the first and last ranges for
// the end checks, then binary-search the table with one read per probe.
// An add that opens a new range in the middle or at the front, or that
// merges two ranges, moves every later entry one place through the table's
// read and write ports at one entry per cycle.
module coalescing_integer_range_set_unit #(
  parameter int MAX_RANGES = 256
) (
  input  logic          clk,
  input  logic          rst,
  cirs_cmd_if.sink      cmd,
  cirs_rsp_if.source    rsp
);
  import cirs_pkg::*;

  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);

  state_t state, state_next;

  action_t                    act;
  logic signed [VALUE_W-1:0]  val;
  logic [CW-1:0]              used;
  logic [COUNT_W-1:0]         count;

  // search window: first start, end of low neighbor, high neighbor range
  logic signed [VALUE_W-1:0]  first_start;
  logic signed [VALUE_W-1:0]  lo_end;
  logic signed [VALUE_W-1:0]  hi_start;
  logic signed [VALUE_W-1:0]  hi_end;
  logic [AW-1:0]              lo, hi, mid;

  // shift engine
  logic                       sh_up;
  logic [AW-1:0]              sh_idx, sh_stop, sh_waddr, pos;
  logic                       sh_pend;

  logic                       res_present, res_status;

  logic                       rsp_valid, rsp_present, rsp_status;
  logic [TOTAL_W-1:0]         rsp_range_total;
  logic [COUNT_W-1:0]         rsp_element_total;

  // table port
  logic [AW-1:0]              rd_addr, wr_addr;
  logic signed [VALUE_W-1:0]  rd_start, rd_end, wr_sdata, wr_edata;
  mem_wen_t                   wen;

  // shared decision logic
  logic [AW-1:0]  last;
  logic           full, above, below, hit_ends, nx_a, pv_b;
  logic           step_more, in_le, in_ge, out_free;
  logic [AW:0]    mid_sum;
  logic [AW-1:0]  mid_c;

  cirs_range_mem #(.DEPTH(MAX_RANGES)) u_mem (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_start (rd_start),
    .rd_end   (rd_end),
    .wen      (wen),
    .wr_addr  (wr_addr),
    .wr_sdata (wr_sdata),
    .wr_edata (wr_edata)
  );

  assign last      = AW'(used - CW'(1));
  assign full      = (used == CW'(MAX_RANGES));
  assign above     = val > hi_end;
  assign below     = val < first_start;
  assign hit_ends  = (val <= lo_end) || (val >= hi_start);
  // one adjacency unit each side, shared between end checks and decide
  assign nx_a      = is_next(val, (state == S_CHECK) ? hi_end : lo_end);
  assign pv_b      = is_prev(val, (state == S_CHECK) ? first_start : hi_start);
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid_c     = mid_sum[AW:1];
  assign step_more = ({1'b0, lo} + (AW+1)'(1)) < {1'b0, hi};
  assign in_le     = val <= rd_end;
  assign in_ge     = val >= rd_start;
  assign out_free  = !rsp_valid || rsp.ready;

  assign cmd.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.present       = rsp_present;
  assign rsp.status        = rsp_status;
  assign rsp.range_total   = rsp_range_total;
  assign rsp.element_total = rsp_element_total;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and table port control
  always_comb begin
    state_next = state;
    rd_addr    = '0;
    wen        = '0;
    wr_addr    = sh_waddr;
    wr_sdata   = rd_start;
    wr_edata   = rd_end;
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          wr_sdata = cmd.value;
          wr_edata = cmd.value;
          wr_addr  = '0;
          case (action_t'(cmd.action))
            ACT_ADD, ACT_FIND: begin
              if (used == '0) begin
                wen.wr_start = (action_t'(cmd.action) == ACT_ADD);
                wen.wr_end   = (action_t'(cmd.action) == ACT_ADD);
                state_next   = S_DONE;
              end else begin
                state_next = S_RD_FIRST;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_RD_FIRST: begin
        rd_addr    = last;
        state_next = S_RD_LAST;
      end
      S_RD_LAST: state_next = S_CHECK;
      S_CHECK: begin
        wr_sdata   = val;
        wr_edata   = val;
        state_next = S_DONE;
        if (above) begin
          if (act == ACT_ADD) begin
            if (nx_a) begin
              wen.wr_end = 1'b1;
              wr_addr    = last;
            end else if (!full) begin
              wen.wr_start = 1'b1;
              wen.wr_end   = 1'b1;
              wr_addr      = AW'(used);
            end
          end
        end else if (below) begin
          if (act == ACT_ADD) begin
            if (pv_b) begin
              wen.wr_start = 1'b1;
              wr_addr      = '0;
            end else if (!full) begin
              state_next = S_SHIFT;
            end
          end
        end else if (!hit_ends) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (step_more) begin
          rd_addr    = mid_c;
          state_next = S_SEARCH;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_SEARCH: begin
        state_next = (in_le && in_ge) ? S_DONE : S_STEP;
      end
      S_DECIDE: begin
        wr_sdata   = val;
        wr_edata   = val;
        state_next = S_DONE;
        if (act == ACT_ADD) begin
          if (nx_a && pv_b) begin
            // bridge: low range absorbs high range, later entries move down
            wen.wr_end = 1'b1;
            wr_addr    = lo;
            wr_edata   = hi_end;
            if (hi != last) begin
              state_next = S_SHIFT;
            end
          end else if (nx_a) begin
            wen.wr_end = 1'b1;
            wr_addr    = lo;
          end else if (pv_b) begin
            wen.wr_start = 1'b1;
            wr_addr      = hi;
          end else if (!full) begin
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        rd_addr = sh_idx;
        if (sh_idx == sh_stop) begin
          state_next = S_SHIFT_END;
        end
      end
      S_SHIFT_END: state_next = sh_up ? S_PUT : S_DONE;
      S_PUT: begin
        wen.wr_start = 1'b1;
        wen.wr_end   = 1'b1;
        wr_addr      = pos;
        wr_sdata     = val;
        wr_edata     = val;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // moved entry from the previous shift read
    if (sh_pend) begin
      wen.wr_start = 1'b1;
      wen.wr_end   = 1'b1;
      wr_addr      = sh_waddr;
      wr_sdata     = rd_start;
      wr_edata     = rd_end;
    end
  end

  // set counters
  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            if (action_t'(cmd.action) == ACT_CLEAR) begin
              used  <= '0;
              count <= '0;
            end else if (action_t'(cmd.action) == ACT_ADD && used == '0) begin
              used  <= CW'(1);
              count <= count + COUNT_W'(1);
            end
          end
        end
        S_CHECK: begin
          if (act == ACT_ADD) begin
            if (above) begin
              if (nx_a) begin
                count <= count + COUNT_W'(1);
              end else if (!full) begin
                used  <= used + CW'(1);
                count <= count + COUNT_W'(1);
              end
            end else if (below && pv_b) begin
              count <= count + COUNT_W'(1);
            end
          end
        end
        S_DECIDE: begin
          if (act == ACT_ADD) begin
            if (nx_a && pv_b) begin
              used  <= used - CW'(1);
              count <= count + COUNT_W'(1);
            end else if (nx_a || pv_b) begin
              count <= count + COUNT_W'(1);
            end
          end
        end
        S_PUT: begin
          used  <= used + CW'(1);
          count <= count + COUNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // shift write pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sh_pend <= 1'b0;
    end else begin
      sh_pend <= (state == S_SHIFT);
    end
  end

  // working registers of one command
  always_ff @(posedge clk) begin
    sh_waddr <= sh_up ? (sh_idx + AW'(1)) : (sh_idx - AW'(1));
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          act         <= action_t'(cmd.action);
          val         <= cmd.value;
          res_present <= 1'b0;
          res_status  <= 1'b0;
        end
      end
      S_RD_FIRST: begin
        first_start <= rd_start;
        lo_end      <= rd_end;
        lo          <= '0;
      end
      S_RD_LAST: begin
        hi_start <= rd_start;
        hi_end   <= rd_end;
        hi       <= last;
      end
      S_CHECK: begin
        if (above) begin
          if (act == ACT_ADD && !nx_a && full) begin
            res_status <= 1'b1;
          end
        end else if (below) begin
          if (act == ACT_ADD && !pv_b) begin
            if (full) begin
              res_status <= 1'b1;
            end else begin
              sh_up   <= 1'b1;
              sh_idx  <= last;
              sh_stop <= '0;
              pos     <= '0;
            end
          end
        end else if (hit_ends) begin
          res_present <= 1'b1;
        end
      end
      S_STEP: mid <= mid_c;
      S_SEARCH: begin
        if (in_le) begin
          if (in_ge) begin
            res_present <= 1'b1;
          end else begin
            hi       <= mid;
            hi_start <= rd_start;
            hi_end   <= rd_end;
          end
        end else begin
          lo     <= mid;
          lo_end <= rd_end;
        end
      end
      S_DECIDE: begin
        if (act == ACT_ADD) begin
          if (nx_a && pv_b) begin
            sh_up   <= 1'b0;
            sh_idx  <= hi + AW'(1);
            sh_stop <= last;
          end else if (!nx_a && !pv_b) begin
            if (full) begin
              res_status <= 1'b1;
            end else begin
              sh_up   <= 1'b1;
              sh_idx  <= last;
              sh_stop <= hi;
              pos     <= hi;
            end
          end
        end
      end
      S_SHIFT: sh_idx <= sh_up ? (sh_idx - AW'(1)) : (sh_idx + AW'(1));
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp_present       <= res_present;
      rsp_status        <= res_status;
      rsp_range_total   <= TOTAL_W'(used);
      rsp_element_total <= count;
    end
  end

  // every stored range holds at least one element
  assert property (@(posedge clk) disable iff (rst) count >= COUNT_W'(used))
    else $error("range count exceeds element count");

  assert property (@(posedge clk) disable iff (rst) used <= CW'(MAX_RANGES))
    else $error("range table overfilled");

  // a refused add only happens on a full table
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_DONE && res_status) |-> full)
    else $error("add refused with room in table");

  // a new result is loaded only on leaving the done state
  assert property (@(posedge clk) disable iff (rst)
                   $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("result raised outside done state");

  // shift writes only drain from the shift states
  assert property (@(posedge clk) disable iff (rst)
                   sh_pend |-> (state == S_SHIFT || state == S_SHIFT_END))
    else $error("stray shift write");

endmodule

// File: test/coalescing_integer_range_set_unit_tb.sv
`timescale 1ns / 1ps

module coalescing_integer_range_set_unit_tb;
  import cirs_pkg::*;

  localparam int TABLE_DEPTH  = 256;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_ITEMS   = 200;
  localparam int HOLD_AT      = 700;   // result count that triggers the long receiver stall
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;

  localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  // One predicted response
  typedef struct packed {
    logic               present;
    logic               status;
    logic [TOTAL_W-1:0] ranges;
    logic [COUNT_W-1:0] elems;
  } range_outcome_t;

  // Shadow copy of the range table plus the queue of predicted responses
  class range_set_scoreboard;
    longint         lo_tab[TABLE_DEPTH];
    longint         hi_tab[TABLE_DEPTH];
    int             used;
    logic [COUNT_W-1:0] elems;
    int             errors;
    range_outcome_t pending[$];

    function new();
      used   = 0;
      elems  = '0;
      errors = 0;
    endfunction

    // New singleton at pos, later entries move up one
    function bit open_at(int pos, longint v);
      if (used >= TABLE_DEPTH) return 1'b0;
      for (int i = used; i > pos; i--) begin
        lo_tab[i] = lo_tab[i-1];
        hi_tab[i] = hi_tab[i-1];
      end
      lo_tab[pos] = v;
      hi_tab[pos] = v;
      used++;
      return 1'b1;
    endfunction

    // Bisect the inner gaps; on a miss l and r are the ranges around v
    function bit probe_inner(longint v, output int l, output int r);
      int m;
      l = 0;
      r = used - 1;
      while (l + 1 < r) begin
        m = (l + r) / 2;
        if (v <= hi_tab[m]) begin
          if (v >= lo_tab[m]) return 1'b1;
          r = m;
        end else begin
          l = m;
        end
      end
      return 1'b0;
    endfunction

    function bit holds(longint v);
      int l, r;
      if (used == 0) return 1'b0;
      if (v < lo_tab[0] || v > hi_tab[used-1]) return 1'b0;
      if (v <= hi_tab[0] || v >= lo_tab[used-1]) return 1'b1;
      return probe_inner(v, l, r);
    endfunction

    // Returns 1 when the add is refused for lack of a free range
    function bit add_value(longint v);
      int l, r, last;
      if (used == 0) begin
        void'(open_at(0, v));
        elems++;
        return 1'b0;
      end
      last = used - 1;
      // above the top range
      if (v > hi_tab[last]) begin
        if (v == hi_tab[last] + 1) hi_tab[last] = v;
        else if (!open_at(used, v)) return 1'b1;
        elems++;
        return 1'b0;
      end
      // below the bottom range
      if (v < lo_tab[0]) begin
        if (v == lo_tab[0] - 1) lo_tab[0] = v;
        else if (!open_at(0, v)) return 1'b1;
        elems++;
        return 1'b0;
      end
      if (v <= hi_tab[0] || v >= lo_tab[last]) return 1'b0;
      if (probe_inner(v, l, r)) return 1'b0;
      // inner gap: extend, bridge or open
      if (v == hi_tab[l] + 1) begin
        if (v == lo_tab[r] - 1) begin
          hi_tab[l] = hi_tab[r];
          for (int i = r; i < last; i++) begin
            lo_tab[i] = lo_tab[i+1];
            hi_tab[i] = hi_tab[i+1];
          end
          used = last;
        end else begin
          hi_tab[l] = v;
        end
      end else if (v == lo_tab[r] - 1) begin
        lo_tab[r] = v;
      end else if (!open_at(r, v)) begin
        return 1'b1;
      end
      elems++;
      return 1'b0;
    endfunction

    // Command transfer accepted: update the shadow set, queue the response
    function void note_command(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] val);
      longint         v;
      range_outcome_t o;
      v = longint'(val);
      o.present = 1'b0;
      o.status  = 1'b0;
      case (act)
        ACT_ADD: begin
          o.present = holds(v);
          o.status  = add_value(v);
        end
        ACT_FIND: o.present = holds(v);
        ACT_CLEAR: begin
          used  = 0;
          elems = '0;
        end
        default: ;
      endcase
      o.ranges = TOTAL_W'(used);
      o.elems  = elems;
      pending = {pending, o};
    endfunction

    // Response transfer accepted: compare with the oldest prediction
    function void check_response(logic present, logic status,
                                 logic [TOTAL_W-1:0] ranges, logic [COUNT_W-1:0] count);
      range_outcome_t o;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response: present %0d status %0d ranges %0d elements %0d",
                 $time, present, status, ranges, count);
        errors++;
        return;
      end
      o = pending.pop_front();
      if (present !== o.present) begin
        $display("%0t: present: expected %0d actual %0d", $time, o.present, present);
        errors++;
      end
      if (status !== o.status) begin
        $display("%0t: status: expected %0d actual %0d", $time, o.status, status);
        errors++;
      end
      if (ranges !== o.ranges) begin
        $display("%0t: range_total: expected %0d actual %0d", $time, o.ranges, ranges);
        errors++;
      end
      if (count !== o.elems) begin
        $display("%0t: element_total: expected %0d actual %0d", $time, o.elems, count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic calm;

  cirs_cmd_if cmd_bus ();
  cirs_rsp_if rsp_bus ();

  range_set_scoreboard sb = new();

  coalescing_integer_range_set_unit #(
    .MAX_RANGES(TABLE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .rsp(rsp_bus)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout
  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Response side: random short stalls, one long stall, none at the end
  int hold_left    = 0;
  int burst_left   = 0;
  int results_seen = 0;

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      sb.check_response(rsp_bus.present, rsp_bus.status,
                        rsp_bus.range_total, rsp_bus.element_total);
      results_seen++;
      if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (calm) begin
      rsp_bus.ready <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      rsp_bus.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 3) - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Offer one command and wait for its transfer; may idle first
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] v);
    if (!calm && $urandom_range(0, 4) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd_bus.valid  <= 1'b1;
    cmd_bus.action <= act;
    cmd_bus.value  <= v;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    sb.note_command(act, v);
  endtask

  // Cluster center for the random part, sometimes near the integer extremes
  function automatic int pick_hub();
    case ($urandom_range(0, 9))
      0:       return int'(VAL_MIN) + int'($urandom_range(0, 64));
      1:       return int'(VAL_MAX) - int'($urandom_range(0, 64));
      default: return int'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin
    int              hub;
    int              roll;
    int              base;
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  v;

    // Known values on the command side before the first edge
    rst             <= 1'b1;
    calm            = 1'b0;
    cmd_bus.valid   <= 1'b0;
    cmd_bus.action  <= ACT_NONE;
    cmd_bus.value   <= '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty set, extremes, no wrap across the ends
    send_item(ACT_FIND, 32'd0);
    send_item(ACT_ADD, VAL_MAX);
    send_item(ACT_ADD, VAL_MIN);
    send_item(ACT_FIND, VAL_MIN);
    send_item(ACT_FIND, VAL_MAX);
    send_item(ACT_ADD, VAL_MAX - 1);     // neighbor grows down
    send_item(ACT_ADD, VAL_MIN + 1);     // neighbor grows up
    send_item(ACT_ADD, 32'd0);           // inner singleton
    send_item(ACT_ADD, 32'd2);
    send_item(ACT_ADD, 32'd1);           // bridges two ranges
    send_item(ACT_ADD, 32'd1);           // already present
    send_item(ACT_FIND, 32'd7);
    send_item(ACT_NONE, 32'hFFFF_FFFF);
    send_item(ACT_CLEAR, 32'hFFFF_FFFF);
    send_item(ACT_FIND, 32'd0);
    send_item(ACT_ADD, VAL_MIN);
    send_item(ACT_ADD, VAL_MAX);         // append, not an extend
    send_item(ACT_CLEAR, 32'd0);
    send_item(ACT_ADD, 32'd100);
    send_item(ACT_ADD, 32'd101);         // top range grows up
    send_item(ACT_ADD, 32'd99);          // bottom range grows down
    send_item(ACT_ADD, 32'd200);         // append
    send_item(ACT_ADD, 32'd50);          // prepend
    send_item(ACT_CLEAR, 32'h5A5A_A5A5);

    // Fill the table to capacity with singletons, then probe refusals
    base = int'($urandom_range(0, 1 << 20)) - (1 << 19);
    for (int i = 0; i < TABLE_DEPTH; i++) send_item(ACT_ADD, base + 2 * i);
    send_item(ACT_ADD, base + 2000);     // refused, append
    send_item(ACT_ADD, base - 10);       // refused, prepend
    send_item(ACT_ADD, base + 1);        // merge still allowed
    send_item(ACT_ADD, base + 1000);     // back to full
    send_item(ACT_ADD, base + 700);      // refused, inner
    send_item(ACT_ADD, base + 511);      // inner extend while full
    send_item(ACT_ADD, base + 999);      // top range grows down
    send_item(ACT_ADD, base - 1);        // bottom range grows down
    send_item(ACT_FIND, base + 700);
    send_item(ACT_FIND, base + 3);
    send_item(ACT_CLEAR, 32'd0);

    // Random: clustered adds and finds with some noise
    hub = pick_hub();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if ($urandom_range(0, 199) == 0) hub = pick_hub();
      roll = $urandom_range(0, 99);
      if (roll < 2) act = ACT_CLEAR;
      else if (roll < 4) act = ACT_NONE;
      else if (roll < 64) act = ACT_ADD;
      else act = ACT_FIND;
      if ($urandom_range(0, 9) == 0) v = $urandom;
      else v = hub + int'($urandom_range(0, 127)) - 64;
      send_item(act, v);
      if (act == ACT_CLEAR) hub = pick_hub();
    end
    cmd_bus.valid <= 1'b0;

    // Drain
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
src/cirs_pkg.sv
src/cirs_cmd_if.sv
src/cirs_rsp_if.sv
src/cirs_range_mem.sv
src/coalescing_integer_range_set_unit.sv
test/coalescing_integer_range_set_unit_tb.sv
